// File: rtl/mahf_pkg.sv
`timescale 1ns / 1ps
package mahf_pkg;

   // Field bounds that follow from the largest allowed bin counts.
   localparam int BIN_W  = 6;
   localparam int SLOT_W = 11;
   localparam int ADDR_W = BIN_W + SLOT_W;
   localparam int AXES    = 3;
   localparam int CLASSES = 3;
   localparam int RATIO_FRAC = 14;

   localparam logic ACTION_FILL = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic [1:0] AXIS_ETA    = 2'd0;
   localparam logic [1:0] AXIS_PT     = 2'd1;
   localparam logic [1:0] AXIS_ENERGY = 2'd2;
   localparam logic [1:0] AXIS_NONE   = 2'd3;

   localparam logic [1:0] CLASS_ALL    = 2'd0;
   localparam logic [1:0] CLASS_CONV   = 2'd1;
   localparam logic [1:0] CLASS_UNCONV = 2'd2;
   localparam logic [1:0] CLASS_NONE   = 2'd3;

   localparam logic [2:0] REG_ETA_LOW      = 3'd0;
   localparam logic [2:0] REG_ETA_WIDTH    = 3'd1;
   localparam logic [2:0] REG_PT_LOW       = 3'd2;
   localparam logic [2:0] REG_PT_WIDTH     = 3'd3;
   localparam logic [2:0] REG_ENERGY_LOW   = 3'd4;
   localparam logic [2:0] REG_ENERGY_WIDTH = 3'd5;

   localparam logic [15:0] RST_ETA_LOW      = 16'd13107;
   localparam logic [15:0] RST_ETA_WIDTH    = 16'd451;
   localparam logic [15:0] RST_PT_LOW       = 16'd320;
   localparam logic [15:0] RST_PT_WIDTH     = 16'd128;
   localparam logic [15:0] RST_ENERGY_LOW   = 16'd480;
   localparam logic [15:0] RST_ENERGY_WIDTH = 16'd272;

   typedef struct packed {
      logic [15:0] eta_low;
      logic [15:0] eta_width;
      logic [15:0] pt_low;
      logic [15:0] pt_width;
      logic [15:0] energy_low;
      logic [15:0] energy_width;
   } mahf_cfg_type;

   // One classified operation handed from the front to the back.
   typedef struct packed {
      logic                       is_read;
      logic                       bad;
      logic [1:0]                 axis;
      logic [1:0]                 cls;
      logic [SLOT_W-1:0]          slot;
      logic [AXES-1:0]            hit;
      logic [AXES-1:0][BIN_W-1:0] bin;
   } mahf_cmd_type;

endpackage

// File: rtl/mahf_req_if.sv
`timescale 1ns / 1ps
interface mahf_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [16:0] eta;
   logic signed [16:0] pt;
   logic signed [16:0] energy;
   logic signed [15:0] ratio;
   logic               converted;
   logic [1:0]         read_axis;
   logic [1:0]         read_class;
   logic [4:0]         read_axis_bin;
   logic [7:0]         read_ratio_bin;

   modport source (output valid, action, eta, pt, energy, ratio, converted, read_axis,
                   read_class, read_axis_bin, read_ratio_bin, input ready);
   modport sink (input valid, action, eta, pt, energy, ratio, converted, read_axis,
                 read_class, read_axis_bin, read_ratio_bin, output ready);
endinterface

// File: rtl/mahf_rsp_if.sv
`timescale 1ns / 1ps
interface mahf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] count;
   logic        bad_address;

   modport source (output valid, count, bad_address, input ready);
   modport sink (input valid, count, bad_address, output ready);
endinterface

// File: rtl/mahf_ram.sv
`timescale 1ns / 1ps
module mahf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/mahf_fifo.sv
`timescale 1ns / 1ps
module mahf_fifo #(
   parameter type ITEM_TYPE = mahf_pkg::mahf_cmd_type,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  ITEM_TYPE push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output ITEM_TYPE pop_item
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ITEM_TYPE        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

// File: rtl/mahf_front.sv
`timescale 1ns / 1ps
module mahf_front #(
   parameter int ETA_BINS    = 20,
   parameter int PT_BINS     = 10,
   parameter int ENERGY_BINS = 10,
   parameter int RATIO_BINS  = 200
) (
   input  logic                  clock,
   input  logic                  reset,
   mahf_req_if.sink              req_bus,
   input  logic                  clear_busy,
   input  mahf_pkg::mahf_cfg_type cfg,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output mahf_pkg::mahf_cmd_type cmd
);
   import mahf_pkg::*;

   localparam int MAX_BINS = (ETA_BINS > PT_BINS) ?
                             ((ETA_BINS > ENERGY_BINS) ? ETA_BINS : ENERGY_BINS) :
                             ((PT_BINS > ENERGY_BINS) ? PT_BINS : ENERGY_BINS);
   localparam int QB    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int SW    = (QB > 1) ? $clog2(QB) : 1;
   localparam int DW    = 17 + QB;
   localparam int LIM_W = 23;
   localparam int SLOTS = RATIO_BINS + 2;
   localparam int PROD_W = RATIO_FRAC + SLOT_W;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_OUT  = 2'd2;

   localparam int AXIS_BINS [AXES] = '{ETA_BINS, PT_BINS, ENERGY_BINS};

   logic [1:0]          state_ff, state_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [DW-1:0]       rem_ff [AXES];
   logic [DW-1:0]       rem_in [AXES];
   logic [QB-1:0]       q_ff [AXES];
   logic [QB-1:0]       q_in [AXES];
   logic [AXES-1:0]     hit_ff, hit_in;
   logic                is_read_ff, is_read_in, bad_ff, bad_in;
   logic [1:0]          axis_ff, axis_in, cls_ff, cls_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [BIN_W-1:0]    rbin_ff, rbin_in;

   logic [16:0]         mag [AXES];
   logic [15:0]         lo [AXES];
   logic [15:0]         wd [AXES];
   logic [16:0]         diff [AXES];
   logic [AXES-1:0]     hit_new;
   logic [DW-1:0]       divisor [AXES];
   logic [PROD_W-1:0]   ratio_prod;
   logic [SLOT_W-1:0]   slot_new;
   logic [6:0]          read_nb;
   logic                read_bad;
   logic                req_ready;

   assign req_ready     = (state_ff == F_IDLE) && !clear_busy;
   assign req_bus.ready = req_ready;

   assign mag[0] = req_bus.eta[16] ? 17'(-req_bus.eta) : 17'(req_bus.eta);
   assign mag[1] = req_bus.pt[16] ? 17'(-req_bus.pt) : 17'(req_bus.pt);
   assign mag[2] = req_bus.energy[16] ? 17'(-req_bus.energy) : 17'(req_bus.energy);
   assign lo[0]  = cfg.eta_low;
   assign lo[1]  = cfg.pt_low;
   assign lo[2]  = cfg.energy_low;
   assign wd[0]  = cfg.eta_width;
   assign wd[1]  = cfg.pt_width;
   assign wd[2]  = cfg.energy_width;

   // A value lands in some bin when it lies strictly above the low edge and
   // strictly below the upper end of the grid; edge hits are removed later.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         diff[a]    = mag[a] - 17'(lo[a]);
         hit_new[a] = (wd[a] != '0) && (mag[a] > 17'(lo[a])) &&
                      (LIM_W'(diff[a]) < LIM_W'(AXIS_BINS[a]) * LIM_W'(wd[a]));
         divisor[a] = DW'(wd[a]) << step_ff;
      end
   end

   assign ratio_prod = PROD_W'(req_bus.ratio[RATIO_FRAC-1:0]) * PROD_W'(RATIO_BINS);

   always_comb begin
      if (req_bus.ratio[15]) begin
         slot_new = '0;
      end else if (req_bus.ratio[RATIO_FRAC]) begin
         slot_new = SLOT_W'(RATIO_BINS + 1);
      end else begin
         slot_new = SLOT_W'(ratio_prod >> RATIO_FRAC) + 1'b1;
      end
   end

   always_comb begin
      case (req_bus.read_axis)
         AXIS_ETA:    read_nb = 7'(ETA_BINS);
         AXIS_PT:     read_nb = 7'(PT_BINS);
         AXIS_ENERGY: read_nb = 7'(ENERGY_BINS);
         default:     read_nb = '0;
      endcase
      read_bad = (req_bus.read_axis == AXIS_NONE) || (req_bus.read_class == CLASS_NONE) ||
                 (7'(req_bus.read_axis_bin) >= read_nb) ||
                 (SLOT_W'(req_bus.read_ratio_bin) >= SLOT_W'(SLOTS));
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      hit_in     = hit_ff;
      is_read_in = is_read_ff;
      bad_in     = bad_ff;
      axis_in    = axis_ff;
      cls_in     = cls_ff;
      slot_in    = slot_ff;
      rbin_in    = rbin_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_bus.valid && req_ready) begin
               if (req_bus.action == ACTION_READ) begin
                  is_read_in = 1'b1;
                  bad_in     = read_bad;
                  axis_in    = req_bus.read_axis;
                  cls_in     = req_bus.read_class;
                  slot_in    = SLOT_W'(req_bus.read_ratio_bin);
                  rbin_in    = BIN_W'(req_bus.read_axis_bin);
                  hit_in     = '0;
                  state_in   = F_OUT;
               end else begin
                  is_read_in = 1'b0;
                  bad_in     = 1'b0;
                  axis_in    = AXIS_ETA;
                  cls_in     = req_bus.converted ? CLASS_CONV : CLASS_UNCONV;
                  slot_in    = slot_new;
                  hit_in     = hit_new;
                  for (int a = 0; a < AXES; a++) begin
                     rem_in[a] = DW'(diff[a]);
                     q_in[a]   = '0;
                  end
                  step_in  = SW'(QB - 1);
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            // Restoring division, one quotient bit per cycle on all axes.
            for (int a = 0; a < AXES; a++) begin
               if (rem_ff[a] >= divisor[a]) begin
                  rem_in[a] = rem_ff[a] - divisor[a];
                  q_in[a]   = (q_ff[a] << 1) | QB'(1);
               end else begin
                  q_in[a] = q_ff[a] << 1;
               end
            end
            if (step_ff == '0) begin
               state_in = F_OUT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         F_OUT: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      cmd_valid   = (state_ff == F_OUT);
      cmd.is_read = is_read_ff;
      cmd.bad     = bad_ff;
      cmd.axis    = axis_ff;
      cmd.cls     = cls_ff;
      cmd.slot    = slot_ff;
      for (int a = 0; a < AXES; a++) begin
         // A zero remainder means the value sat exactly on an inner edge.
         cmd.hit[a] = hit_ff[a] && (rem_ff[a] != '0);
         cmd.bin[a] = is_read_ff ? rbin_ff : BIN_W'(q_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      hit_ff     <= hit_in;
      is_read_ff <= is_read_in;
      bad_ff     <= bad_in;
      axis_ff    <= axis_in;
      cls_ff     <= cls_in;
      slot_ff    <= slot_in;
      rbin_ff    <= rbin_in;
   end
endmodule

// File: rtl/mahf_back.sv
`timescale 1ns / 1ps
module mahf_back #(
   parameter int ETA_BINS    = 20,
   parameter int PT_BINS     = 10,
   parameter int ENERGY_BINS = 10,
   parameter int RATIO_BINS  = 200,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  mahf_pkg::mahf_cmd_type cmd,
   mahf_rsp_if.source             rsp_bus,
   output logic                   clear_busy
);
   import mahf_pkg::*;

   localparam int MAX_BINS = (ETA_BINS > PT_BINS) ?
                             ((ETA_BINS > ENERGY_BINS) ? ETA_BINS : ENERGY_BINS) :
                             ((PT_BINS > ENERGY_BINS) ? PT_BINS : ENERGY_BINS);
   localparam int SLOTS     = RATIO_BINS + 2;
   localparam int MAX_DEPTH = MAX_BINS * SLOTS;
   localparam int CLW       = $clog2(MAX_DEPTH);
   localparam int AXIS_BINS [AXES] = '{ETA_BINS, PT_BINS, ENERGY_BINS};

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_WR    = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CLW-1:0]         clr_ff, clr_in;
   mahf_cmd_type           cmd_ff;
   logic [ADDR_W-1:0]      addr_in [AXES];
   logic [ADDR_W-1:0]      addr_ff [AXES];
   logic [COUNT_WIDTH-1:0] rdata [AXES][CLASSES];
   logic [COUNT_WIDTH-1:0] sel_count;
   logic [COUNT_WIDTH+31:0] sel_ext;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            count_ff, count_in;
   logic                   bad_ff, bad_in;
   logic                   pop;

   assign clear_busy = (state_ff == B_CLEAR);
   assign pop        = (state_ff == B_IDLE) && cmd_valid &&
                       !(cmd.is_read && rsp_valid_ff && !rsp_bus.ready);
   assign cmd_ready  = pop;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         addr_in[a] = ADDR_W'(cmd.bin[a]) * ADDR_W'(SLOTS) + ADDR_W'(cmd.slot);
      end
   end

   // One bank per axis and class, so an event touches at most six distinct banks.
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      for (genvar c = 0; c < CLASSES; c++) begin : g_cls
         localparam int DEPTH = AXIS_BINS[a] * SLOTS;
         localparam int AW    = $clog2(DEPTH);
         logic                   we;
         logic [AW-1:0]          waddr;
         logic [COUNT_WIDTH-1:0] wdata;
         logic [COUNT_WIDTH-1:0] rd;

         always_comb begin
            we    = 1'b0;
            waddr = addr_ff[a][AW-1:0];
            wdata = (rd == '1) ? rd : rd + 1'b1;
            if (state_ff == B_CLEAR) begin
               we    = (ADDR_W'(clr_ff) < ADDR_W'(DEPTH));
               waddr = AW'(clr_ff);
               wdata = '0;
            end else if (state_ff == B_WR) begin
               we = !cmd_ff.is_read && cmd_ff.hit[a] &&
                    ((c == 0) || (cmd_ff.cls == 2'(c)));
            end
         end

         mahf_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
            .clock (clock),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (addr_in[a][AW-1:0]),
            .rdata (rd)
         );

         assign rdata[a][c] = rd;
      end
   end

   always_comb begin
      sel_count = '0;
      for (int a = 0; a < AXES; a++) begin
         for (int c = 0; c < CLASSES; c++) begin
            if ((cmd_ff.axis == 2'(a)) && (cmd_ff.cls == 2'(c))) begin
               sel_count = rdata[a][c];
            end
         end
      end
      sel_ext = {32'b0, sel_count};
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      count_in     = count_ff;
      bad_in       = bad_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_ff == CLW'(MAX_DEPTH - 1)) begin
               state_in = B_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (pop) begin
               state_in = B_WR;
            end
         end
         B_WR: begin
            if (cmd_ff.is_read) begin
               rsp_valid_in = 1'b1;
               bad_in       = cmd_ff.bad;
               if (cmd_ff.bad) begin
                  count_in = '0;
               end else if (sel_ext[COUNT_WIDTH+31:32] != '0) begin
                  count_in = '1;
               end else begin
                  count_in = sel_ext[31:0];
               end
            end
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.count       = count_ff;
   assign rsp_bus.bad_address = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         cmd_ff  <= cmd;
         addr_ff <= addr_in;
      end
      count_ff <= count_in;
      bad_ff   <= bad_in;
   end

   // The write cycle of an operation is never followed by another write cycle,
   // so the next read always sees the updated counter.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WR) |=> (state_ff != B_WR))
      else $error("back write cycle repeated");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == B_WR))
      else $error("result raised outside a write cycle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !cmd_ready)
      else $error("command taken during clearing pass");
endmodule

// File: rtl/multi_axis_ratio_histogram_fill_unit.sv
`timescale 1ns / 1ps
// Three-axis histogram of an energy ratio. A fill beat places |eta|, |pt| and
// |energy| each in a uniform bin (strict edges, so a value exactly on an edge is
// dropped) and bumps the ratio's slot in the all-events histogram and in the
// converted or unconverted histogram of every axis that found a bin; counters
// saturate. A read beat returns one counter, or zero with bad_address set when
// the address names no counter. After reset the block clears its counter
// memories; req_bus.ready stays low during that pass, while the register port
// works as usual. The front finds each bin with a restoring divider that yields
// one quotient bit per cycle, while a read skips the divider. The back then
// reads and writes back the banked counter memories for each operation, and a
// two-entry queue between the two lets either side stall alone. A result waits
// in an output register without holding up later fills; a later read waits in
// the queue until that result is taken.
// Registers are written over the APB-style port at 4 * index.
module multi_axis_ratio_histogram_fill_unit #(
   parameter int ETA_BINS    = 20,
   parameter int PT_BINS     = 10,
   parameter int ENERGY_BINS = 10,
   parameter int RATIO_BINS  = 200,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   mahf_req_if.sink    req_bus,
   mahf_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mahf_pkg::*;

   mahf_cfg_type cfg_ff, cfg_in;
   logic [2:0]   reg_index;
   logic         front_valid, front_ready, back_valid, back_ready, clear_busy;
   mahf_cmd_type front_cmd, back_cmd;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];

   // Register writes land on the access cycle of the transfer.
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_index)
            REG_ETA_LOW:      cfg_in.eta_low      = pwdata[15:0];
            REG_ETA_WIDTH:    cfg_in.eta_width    = pwdata[15:0];
            REG_PT_LOW:       cfg_in.pt_low       = pwdata[15:0];
            REG_PT_WIDTH:     cfg_in.pt_width     = pwdata[15:0];
            REG_ENERGY_LOW:   cfg_in.energy_low   = pwdata[15:0];
            REG_ENERGY_WIDTH: cfg_in.energy_width = pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ETA_LOW:      prdata = {16'b0, cfg_ff.eta_low};
         REG_ETA_WIDTH:    prdata = {16'b0, cfg_ff.eta_width};
         REG_PT_LOW:       prdata = {16'b0, cfg_ff.pt_low};
         REG_PT_WIDTH:     prdata = {16'b0, cfg_ff.pt_width};
         REG_ENERGY_LOW:   prdata = {16'b0, cfg_ff.energy_low};
         REG_ENERGY_WIDTH: prdata = {16'b0, cfg_ff.energy_width};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eta_low      <= RST_ETA_LOW;
         cfg_ff.eta_width    <= RST_ETA_WIDTH;
         cfg_ff.pt_low       <= RST_PT_LOW;
         cfg_ff.pt_width     <= RST_PT_WIDTH;
         cfg_ff.energy_low   <= RST_ENERGY_LOW;
         cfg_ff.energy_width <= RST_ENERGY_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front classifies beats: bin search per axis and ratio slot for fills,
   // address check for reads.
   mahf_front #(
      .ETA_BINS    (ETA_BINS),
      .PT_BINS     (PT_BINS),
      .ENERGY_BINS (ENERGY_BINS),
      .RATIO_BINS  (RATIO_BINS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .clear_busy (clear_busy),
      .cfg        (cfg_ff),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   mahf_fifo #(.ITEM_TYPE(mahf_cmd_type), .DEPTH(2)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_cmd)
   );

   // The back owns the nine counter banks and the result register.
   mahf_back #(
      .ETA_BINS    (ETA_BINS),
      .PT_BINS     (PT_BINS),
      .ENERGY_BINS (ENERGY_BINS),
      .RATIO_BINS  (RATIO_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_bus    (rsp_bus),
      .clear_busy (clear_busy)
   );
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Stand-alone bench for the three-axis ratio histogram unit.
module tb;
   import mahf_pkg::*;

   // Geometry of the counter store with the default parameters.
   localparam int N_ETA    = 20;
   localparam int N_PT     = 10;
   localparam int N_ENERGY = 10;
   localparam int N_RATIO  = 200;
   localparam int N_SLOTS  = N_RATIO + 2;
   localparam int N_CELLS  = (N_ETA + N_PT + N_ENERGY) * CLASSES * N_SLOTS;
   localparam int RATIO_TWO_RAW = 16384;
   // Cycles that a fill may still spend inside the block after the last result.
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_PER_PHASE = 305;

   // One request beat as the sender presents it.
   typedef struct {
      logic               action;
      logic signed [16:0] eta;
      logic signed [16:0] pt;
      logic signed [16:0] energy;
      logic signed [15:0] ratio;
      logic               converted;
      logic [1:0]         read_axis;
      logic [1:0]         read_class;
      logic [4:0]         read_axis_bin;
      logic [7:0]         read_ratio_bin;
   } beat_t;

   typedef struct {
      logic [31:0] count;
      logic        bad_address;
   } readout_t;

   // Keeps its own copy of the histogram and the bin registers, and holds the
   // read results that are still owed by the block, oldest first.
   class histogram_scoreboard;
      bit [31:0] cells[N_CELLS];
      int        edge_low[AXES];
      int        bin_width[AXES];
      readout_t  owed_reads[$];
      int        mismatches;
      int        fills, reads, bad_reads, checked;

      function new();
         foreach (cells[i]) cells[i] = '0;
         edge_low[0]  = RST_ETA_LOW;
         bin_width[0] = RST_ETA_WIDTH;
         edge_low[1]  = RST_PT_LOW;
         bin_width[1] = RST_PT_WIDTH;
         edge_low[2]  = RST_ENERGY_LOW;
         bin_width[2] = RST_ENERGY_WIDTH;
         mismatches = 0;
         fills = 0;
         reads = 0;
         bad_reads = 0;
         checked = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [15:0] value);
         case (index)
            REG_ETA_LOW:      edge_low[0] = value;
            REG_ETA_WIDTH:    bin_width[0] = value;
            REG_PT_LOW:       edge_low[1] = value;
            REG_PT_WIDTH:     bin_width[1] = value;
            REG_ENERGY_LOW:   edge_low[2] = value;
            REG_ENERGY_WIDTH: bin_width[2] = value;
            default: ;
         endcase
      endfunction

      static function int bins_on(int axis);
         return axis == 0 ? N_ETA : (axis == 1 ? N_PT : N_ENERGY);
      endfunction

      static function int row_base(int axis);
         return axis == 0 ? 0 : (axis == 1 ? N_ETA : N_ETA + N_PT);
      endfunction

      // Strict edges on both sides: a value on an edge lands nowhere.
      function int locate(int axis, int magnitude);
         int d;
         if (bin_width[axis] == 0 || magnitude <= edge_low[axis]) return -1;
         d = magnitude - edge_low[axis];
         if (d % bin_width[axis] == 0) return -1;
         if (d / bin_width[axis] >= bins_on(axis)) return -1;
         return d / bin_width[axis];
      endfunction

      static function int ratio_slot(logic signed [15:0] r);
         if (r < 0) return 0;
         if (r >= RATIO_TWO_RAW) return N_RATIO + 1;
         return 1 + (int'(r) * N_RATIO) / RATIO_TWO_RAW;
      endfunction

      function void bump(int row, int cls, int slot);
         int idx;
         idx = (row * CLASSES + cls) * N_SLOTS + slot;
         if (cells[idx] != '1) cells[idx]++;
      endfunction

      function void note_request(beat_t b);
         int mags[AXES];
         int slot, cls, bin, axis;
         readout_t owed;
         if (b.action == ACTION_FILL) begin
            fills++;
            mags[0] = b.eta < 0 ? -int'(b.eta) : int'(b.eta);
            mags[1] = b.pt < 0 ? -int'(b.pt) : int'(b.pt);
            mags[2] = b.energy < 0 ? -int'(b.energy) : int'(b.energy);
            slot = ratio_slot(b.ratio);
            cls = b.converted ? int'(CLASS_CONV) : int'(CLASS_UNCONV);
            for (int a = 0; a < AXES; a++) begin
               bin = locate(a, mags[a]);
               if (bin >= 0) begin
                  bump(row_base(a) + bin, CLASS_ALL, slot);
                  bump(row_base(a) + bin, cls, slot);
               end
            end
         end else begin
            reads++;
            axis = b.read_axis;
            if (b.read_axis == AXIS_NONE || b.read_class == CLASS_NONE ||
                b.read_axis_bin >= bins_on(axis) || b.read_ratio_bin >= N_SLOTS) begin
               owed.count = '0;
               owed.bad_address = 1'b1;
               bad_reads++;
            end else begin
               owed.count = cells[((row_base(axis) + b.read_axis_bin) * CLASSES
                                   + b.read_class) * N_SLOTS + b.read_ratio_bin];
               owed.bad_address = 1'b0;
            end
            owed_reads.push_back(owed);
         end
      endfunction

      function void check_result(logic [31:0] count, logic bad_address);
         readout_t want;
         checked++;
         if (owed_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with no read outstanding (count %0d bad %0b)",
                        $realtime, count, bad_address);
            return;
         end
         want = owed_reads.pop_front();
         if (count !== want.count || bad_address !== want.bad_address) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: read result: expected count %0d bad %0b, got count %0d bad %0b",
                        $realtime, want.count, want.bad_address, count, bad_address);
         end
      endfunction

      function int pending();
         return owed_reads.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;

   mahf_req_if req_bus ();
   mahf_rsp_if rsp_bus ();

   multi_axis_ratio_histogram_fill_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   histogram_scoreboard sb = new();

   // Knobs shared between the sender and the receiver process.
   bit quiet;          // no idling in the closing part of the run
   bit long_hold_ask;  // asks the receiver for one long stall
   int hold_left;

   // Remembered from the last fill so that reads mostly land on live counters.
   int last_bin[AXES];
   int last_slot;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The generous run limit; a healthy run ends far earlier.
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   // Both monitors look at values as they stood just before the edge.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         beat_t seen;
         seen.action = req_bus.action;
         seen.eta = req_bus.eta;
         seen.pt = req_bus.pt;
         seen.energy = req_bus.energy;
         seen.ratio = req_bus.ratio;
         seen.converted = req_bus.converted;
         seen.read_axis = req_bus.read_axis;
         seen.read_class = req_bus.read_class;
         seen.read_axis_bin = req_bus.read_axis_bin;
         seen.read_ratio_bin = req_bus.read_ratio_bin;
         sb.note_request(seen);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.count, rsp_bus.bad_address);
   end

   // The receiver stalls in short random bursts, and once for a long stretch
   // so that the internal queue fills up and the block pushes back on the sender.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_ask) begin
         long_hold_ask = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(0, 8);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Presents one beat and returns at the edge where it was taken. Called at a
   // rising edge; a following beat may be driven in the same step.
   task automatic offer(beat_t b);
      req_bus.valid <= 1'b1;
      req_bus.action <= b.action;
      req_bus.eta <= b.eta;
      req_bus.pt <= b.pt;
      req_bus.energy <= b.energy;
      req_bus.ratio <= b.ratio;
      req_bus.converted <= b.converted;
      req_bus.read_axis <= b.read_axis;
      req_bus.read_class <= b.read_class;
      req_bus.read_axis_bin <= b.read_axis_bin;
      req_bus.read_ratio_bin <= b.read_ratio_bin;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic pause_sender(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Waits until every read has been answered and any trailing fill is done.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then the access cycle; the register takes the value at the
   // edge that ends the access cycle.
   task automatic write_register(logic [2:0] index, logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'(index) << 2;
      pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_register(index, value);
   endtask

   task automatic load_bins(int el, int ew, int pl, int pw, int nl, int nw);
      write_register(REG_ETA_LOW, 16'(el));
      write_register(REG_ETA_WIDTH, 16'(ew));
      write_register(REG_PT_LOW, 16'(pl));
      write_register(REG_PT_WIDTH, 16'(pw));
      write_register(REG_ENERGY_LOW, 16'(nl));
      write_register(REG_ENERGY_WIDTH, 16'(nw));
   endtask

   function automatic beat_t fill_beat(int eta, int pt, int energy, int ratio, bit conv);
      beat_t b;
      b = '{default: '0};
      b.action = ACTION_FILL;
      b.eta = 17'(eta);
      b.pt = 17'(pt);
      b.energy = 17'(energy);
      b.ratio = 16'(ratio);
      b.converted = conv;
      b.read_axis = 2'($urandom);
      b.read_class = 2'($urandom);
      b.read_axis_bin = 5'($urandom);
      b.read_ratio_bin = 8'($urandom);
      return b;
   endfunction

   function automatic beat_t read_beat(logic [1:0] axis, logic [1:0] cls, int abin, int rbin);
      beat_t b;
      b.action = ACTION_READ;
      b.eta = 17'($urandom);
      b.pt = 17'($urandom);
      b.energy = 17'($urandom);
      b.ratio = 16'($urandom);
      b.converted = 1'($urandom);
      b.read_axis = axis;
      b.read_class = cls;
      b.read_axis_bin = 5'(abin);
      b.read_ratio_bin = 8'(rbin);
      return b;
   endfunction

   // A signed axis value: mostly inside a chosen bin, sometimes exactly on an
   // edge, sometimes anything at all. The bin it aims at is remembered.
   function automatic int axis_value(int axis);
      int mode, lo, w, n, b, mag;
      mode = $urandom_range(0, 9);
      lo = sb.edge_low[axis];
      w = sb.bin_width[axis];
      n = histogram_scoreboard::bins_on(axis);
      b = $urandom_range(0, n - 1);
      if (mode == 0 || w < 2) mag = $urandom_range(0, 65536);
      else if (mode == 1) mag = lo + $urandom_range(0, n) * w;
      else mag = lo + b * w + $urandom_range(1, w - 1);
      if (mag > 65536) mag = $urandom_range(0, 65536);
      last_bin[axis] = sb.locate(axis, mag);
      if (mag == 65536 || $urandom_range(0, 1)) return -mag;
      return mag;
   endfunction

   function automatic int ratio_value();
      case ($urandom_range(0, 9))
         0: return $signed(16'($urandom));
         1: return RATIO_TWO_RAW + $urandom_range(0, 1);
         2: return -$urandom_range(1, 3);
         default: return $urandom_range(0, RATIO_TWO_RAW - 1);
      endcase
   endfunction

   function automatic beat_t random_beat();
      beat_t b;
      int e, p, n, r;
      if ($urandom_range(0, 3) != 0) begin
         e = axis_value(0);
         p = axis_value(1);
         n = axis_value(2);
         r = ratio_value();
         last_slot = histogram_scoreboard::ratio_slot(16'(r));
         b = fill_beat(e, p, n, r, 1'($urandom));
      end else if ($urandom_range(0, 9) < 7) begin
         // Aim at the counters the last fill touched, in any class.
         b.read_axis = 2'($urandom_range(0, 2));
         b = read_beat(b.read_axis, 2'($urandom_range(0, 2)),
                       last_bin[b.read_axis] >= 0 ? last_bin[b.read_axis]
                          : $urandom_range(0, histogram_scoreboard::bins_on(b.read_axis) - 1),
                       last_slot);
      end else begin
         b = read_beat(2'($urandom), 2'($urandom), 5'($urandom), 8'($urandom));
      end
      return b;
   endfunction

   // One phase of random traffic under the current bin registers.
   task automatic run_phase(int phase);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         if (phase == 1 && i == 40) long_hold_ask = 1'b1;
         if (phase == 2 && i == 150) drain();
         offer(random_beat());
         if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACTION_FILL;
      req_bus.eta = '0;
      req_bus.pt = '0;
      req_bus.energy = '0;
      req_bus.ratio = '0;
      req_bus.converted = 1'b0;
      req_bus.read_axis = AXIS_ETA;
      req_bus.read_class = CLASS_ALL;
      req_bus.read_axis_bin = '0;
      req_bus.read_ratio_bin = '0;
      rsp_bus.ready = 1'b0;
      quiet = 1'b0;
      long_hold_ask = 1'b0;
      hold_left = 0;
      last_bin = '{-1, -1, -1};
      last_slot = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset bin edges. 13558 lies exactly on the first inner
      // eta edge and 14009 on the second, so both are dropped; 14000 lands in bin 1.
      offer(fill_beat(14000, 400, 600, 0, 1'b1));
      offer(fill_beat(-14009, -400, -600, 16383, 1'b0));
      offer(fill_beat(13558, 448, 752, -1, 1'b1));
      offer(fill_beat(-65536, 65535, -65536, -32768, 1'b0));
      offer(fill_beat(65535, 0, 0, 32767, 1'b1));
      offer(fill_beat(13107, 320, 480, 16384, 1'b0));
      offer(fill_beat(14000, 400, 600, 81, 1'b1));
      offer(read_beat(AXIS_ETA, CLASS_ALL, 1, 1));
      offer(read_beat(AXIS_ETA, CLASS_CONV, 1, 1));
      offer(read_beat(AXIS_ETA, CLASS_UNCONV, 1, 200));
      offer(read_beat(AXIS_PT, CLASS_ALL, 0, 0));
      offer(read_beat(AXIS_PT, CLASS_UNCONV, 0, 200));
      offer(read_beat(AXIS_ENERGY, CLASS_ALL, 0, 2));
      offer(read_beat(AXIS_ENERGY, CLASS_CONV, 0, 0));
      offer(read_beat(AXIS_ETA, CLASS_UNCONV, 1, 201));
      offer(read_beat(AXIS_ETA, CLASS_ALL, 19, 201));
      offer(read_beat(AXIS_NONE, CLASS_ALL, 0, 0));
      offer(read_beat(AXIS_ETA, CLASS_NONE, 0, 0));
      offer(read_beat(AXIS_ETA, CLASS_ALL, 20, 0));
      offer(read_beat(AXIS_PT, CLASS_ALL, 10, 0));
      offer(read_beat(AXIS_ENERGY, CLASS_CONV, 31, 0));
      offer(read_beat(AXIS_PT, CLASS_CONV, 9, 202));
      offer(read_beat(AXIS_ENERGY, CLASS_UNCONV, 9, 255));
      drain();

      // Random phases walk through several bin layouts, extremes included:
      // widths of one (every value on an edge), zero width, top low edges.
      run_phase(0);
      load_bins(0, 1, 0, 3000, 0, 6553);
      run_phase(1);
      load_bins(65535, 65535, 100, 0, 1000, 4000);
      run_phase(2);
      load_bins($urandom_range(0, 20000), $urandom_range(1, 4000),
                $urandom_range(0, 20000), $urandom_range(1, 4000),
                $urandom_range(0, 20000), $urandom_range(1, 4000));
      run_phase(3);
      load_bins(8192, 400, 0, 65535, 65535, 1);
      run_phase(4);
      load_bins($urandom_range(0, 3000), $urandom_range(2, 2000),
                $urandom_range(0, 3000), $urandom_range(2, 5000),
                $urandom_range(0, 3000), $urandom_range(2, 5000));
      quiet = 1'b1;
      run_phase(5);

      $display("Run covered %0d fills and %0d reads (%0d to bad addresses) over six bin layouts;",
               sb.fills, sb.reads, sb.bad_reads);
      $display("%0d result beats were checked, %0d mismatched.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/mahf_pkg.sv
rtl/mahf_req_if.sv
rtl/mahf_rsp_if.sv
rtl/mahf_ram.sv
rtl/mahf_fifo.sv
rtl/mahf_front.sv
rtl/mahf_back.sv
rtl/multi_axis_ratio_histogram_fill_unit.sv
bench/tb.sv
